// ===== hdl/segtol_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segtol_pkg
// Shared widths, codes and types for the segment tolerance regression block.
// ============================================================================
package segtol_pkg;

    // Field widths fixed by the waypoint and result formats
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;      // exact coordinate difference
    localparam int SQ_W      = 2 * DIFF_W;       // sum of three squares
    localparam int LEN_W     = 34;               // integer square root width
    localparam int REM_W     = LEN_W + 1;        // square root partial remainder
    localparam int RAD_W     = 2 * LEN_W;        // radicand padded to whole pairs
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 64;               // products wrap at this width
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 6;

    // Iteration counts of the serial units
    localparam int SQ_STEPS   = DIFF_W;
    localparam int ROOT_STEPS = LEN_W;
    localparam int MUL_STEPS  = LEN_W;

    // Saturation bounds of the result
    localparam logic signed [COORD_W-1:0] TOL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] TOL_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET = 3'd0,
        REG_LENGTH = 3'd1,
        REG_DIR_X  = 3'd2,
        REG_DIR_Y  = 3'd3,
        REG_DIR_Z  = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_SQ,
        ST_ROOT_LD,
        ST_ROOT,
        ST_DIV_LD,
        ST_DIV,
        ST_MUL_LD,
        ST_MUL,
        ST_ROUND,
        ST_SUM,
        ST_FIN
    } state_t;

    // Control of a serial unit: load operands, then one step per cycle
    typedef struct packed {
        logic load;
        logic step;
    } seq_ctl_t;

endpackage

// ===== hdl/segtol_sqacc.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segtol_sqacc
// Bit-serial sum of squares: one multiplier bit of all three axes per cycle.
// ============================================================================
module segtol_sqacc (
    input  logic                          clk,
    input  segtol_pkg::seq_ctl_t          ctl,
    input  logic [segtol_pkg::DIFF_W-1:0] mag_x,
    input  logic [segtol_pkg::DIFF_W-1:0] mag_y,
    input  logic [segtol_pkg::DIFF_W-1:0] mag_z,
    output logic [segtol_pkg::SQ_W-1:0]   sum_sq
);
    import segtol_pkg::*;

    logic [DIFF_W-1:0] mcx_reg, mcy_reg, mcz_reg;
    logic [DIFF_W-1:0] shx_reg, shy_reg, shz_reg;
    logic [SQ_W-1:0]   acc_reg;
    logic [SQ_W-1:0]   pp_x, pp_y, pp_z, acc_next;

    // Partial products selected by the current top multiplier bit
    always_comb
    begin
        pp_x     = shx_reg[DIFF_W-1] ? SQ_W'(mcx_reg) : '0;
        pp_y     = shy_reg[DIFF_W-1] ? SQ_W'(mcy_reg) : '0;
        pp_z     = shz_reg[DIFF_W-1] ? SQ_W'(mcz_reg) : '0;
        acc_next = {acc_reg[SQ_W-2:0], 1'b0} + pp_x + pp_y + pp_z;
    end

    // Operand and accumulator registers, most significant bit first
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mcx_reg <= mag_x;
            mcy_reg <= mag_y;
            mcz_reg <= mag_z;
            shx_reg <= mag_x;
            shy_reg <= mag_y;
            shz_reg <= mag_z;
            acc_reg <= '0;
        end
        else if (ctl.step)
        begin
            shx_reg <= {shx_reg[DIFF_W-2:0], 1'b0};
            shy_reg <= {shy_reg[DIFF_W-2:0], 1'b0};
            shz_reg <= {shz_reg[DIFF_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign sum_sq = acc_reg;

endmodule

// ===== hdl/segtol_isqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segtol_isqrt
// Digit-by-digit integer square root, one root bit per cycle, rounded down.
// ============================================================================
module segtol_isqrt (
    input  logic                         clk,
    input  segtol_pkg::seq_ctl_t         ctl,
    input  logic [segtol_pkg::SQ_W-1:0]  radicand,
    output logic [segtol_pkg::LEN_W-1:0] root
);
    import segtol_pkg::*;

    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [LEN_W-1:0] root_reg;
    logic [REM_W+1:0] shifted, trial, diff;
    logic             fits;

    // Bring down the next pair of radicand bits and try a one root bit
    always_comb
    begin
        shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        fits    = (shifted >= trial);
        diff    = shifted - trial;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctl.step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[LEN_W-2:0], fits};
        end
    end

    assign root = root_reg;

endmodule

// ===== hdl/segtol_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segtol_div
// Restoring divider for one unit direction component, rounded to nearest.
// Divides 2*|d|*2^F + L by 2*L, giving one quotient bit per cycle.
// ============================================================================
module segtol_div #(
    parameter int QW = 17
) (
    input  logic                          clk,
    input  segtol_pkg::seq_ctl_t          ctl,
    input  logic [segtol_pkg::DIFF_W-1:0] mag,
    input  logic [segtol_pkg::LEN_W-1:0]  len,
    output logic [QW-1:0]                 quot
);
    import segtol_pkg::*;

    localparam int RW = LEN_W + 1;

    logic [RW-1:0] rem_reg, dvs_reg;
    logic [QW-1:0] low_reg, quot_reg;
    logic [RW:0]   partial, diff;
    logic          fits;

    // Shift in the next dividend bit and compare against the divisor
    always_comb
    begin
        partial = {rem_reg, low_reg[QW-1]};
        fits    = (partial >= {1'b0, dvs_reg});
        diff    = partial - {1'b0, dvs_reg};
    end

    // The dividend's upper part is |d| plus L shifted down by the quotient
    // width, which is below the divisor; its lower part is the low bits of L.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg  <= RW'(mag) + RW'(len >> QW);
            dvs_reg  <= {len, 1'b0};
            low_reg  <= len[QW-1:0];
            quot_reg <= '0;
        end
        else if (ctl.step)
        begin
            rem_reg  <= fits ? diff[RW-1:0] : partial[RW-1:0];
            low_reg  <= {low_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign quot = quot_reg;

endmodule

// ===== hdl/segtol_mul.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segtol_mul
// Shift-and-add coefficient multiplier with a fixed point rounding step.
// The magnitude product wraps at 64 bits and is rounded half away from zero.
// ============================================================================
module segtol_mul #(
    parameter int FRAC = 16,
    parameter int MW   = 34
) (
    input  logic                                clk,
    input  segtol_pkg::seq_ctl_t                ctl,
    input  logic                                rnd,
    input  logic signed [segtol_pkg::COEF_W-1:0] coef,
    input  logic [MW-1:0]                       mplier,
    input  logic                                neg_in,
    output logic [segtol_pkg::PROD_W-FRAC-1:0]  term,
    output logic                                neg
);
    import segtol_pkg::*;

    localparam int TW = PROD_W - FRAC;

    logic [COEF_W-1:0] mcand_reg, coef_mag;
    logic [MW-1:0]     mpl_reg;
    logic [PROD_W-1:0] acc_reg, acc_next, rounded;
    logic [TW-1:0]     term_reg;
    logic              neg_reg;

    always_comb
    begin
        coef_mag = coef[COEF_W-1] ? (~coef + 1'b1) : coef;
        acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                 + (mpl_reg[MW-1] ? PROD_W'(mcand_reg) : '0);
        rounded  = acc_reg + (PROD_W'(1) << (FRAC - 1));
    end

    // Multiplier bits are taken most significant first
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mcand_reg <= coef_mag;
            mpl_reg   <= mplier;
            acc_reg   <= '0;
            neg_reg   <= coef[COEF_W-1] ^ neg_in;
        end
        else if (ctl.step)
        begin
            mpl_reg <= {mpl_reg[MW-2:0], 1'b0};
            acc_reg <= acc_next;
        end

        if (rnd)
        begin
            term_reg <= rounded[PROD_W-1:FRAC];
        end
    end

    assign term = term_reg;
    assign neg  = neg_reg;

endmodule

// ===== hdl/segment_tolerance_regression.sv =====
`timescale 1ns / 1ps
// ============================================================================
// segment_tolerance_regression
// Per-segment tolerance regression over a stream of 3D Q16.16 waypoints.
//
//   Channel  | Direction | Payload
//   ---------+-----------+-------------------------------------------------
//   s_axis   | in        | tdata: point_x, point_y, point_z; tuser: starts_path
//   m_axis   | out       | tdata: tolerance; tuser: zero_length, clipped
//   cfg      | in        | cfg_index selects the coefficient, cfg_data value
//
// A waypoint that starts a trajectory, or the first after reset, is taken while idle and gives no result.
// Any other waypoint passes from its transfer through the bit-serial sum of squares,
// the square root, the three parallel dividers and the four parallel coefficient
// multipliers, with load, round and sum steps, before its result is written to the
// output register.
// The next waypoint is taken as soon as the result has been written, even while
// that result still waits on m_axis_tready; a second result waits for the first.
// Reset clears the coefficients, the previous waypoint flag and the output valid.
// ============================================================================
module segment_tolerance_regression #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Waypoint stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y, [95:64] point_z
    input  logic [0:0]  s_axis_tuser,   // [0] starts_path
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] tolerance
    output logic [1:0]  m_axis_tuser,   // [0] zero_length, [1] clipped
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import segtol_pkg::*;

    localparam int QW    = FRAC_BITS + 1;
    localparam int TW    = PROD_W - FRAC_BITS;
    localparam int SUM_W = TW + 4;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(TOL_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(TOL_MIN);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [COEF_W-1:0] offset_coef_reg, length_coef_reg;
    logic signed [COEF_W-1:0] dir_x_coef_reg, dir_y_coef_reg, dir_z_coef_reg;

    logic                have_prev_reg;
    logic [COORD_W-1:0]  prev_x_reg, prev_y_reg, prev_z_reg;
    logic [DIFF_W-1:0]   dx_reg, dy_reg, dz_reg;
    logic [DIFF_W-1:0]   mag_x, mag_y, mag_z;
    logic [COORD_W-1:0]  pt_x, pt_y, pt_z;
    logic                starts_path;
    logic                zero_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]    addend;
    logic                in_take, seg_take, out_load;

    logic [31:0] tol_reg;
    logic        out_zero_reg, out_clip_reg, out_valid_reg;
    logic [31:0] tol_sat;
    logic        clip_now;

    seq_ctl_t sq_ctl, rt_ctl, dv_ctl, ml_ctl;
    logic     rnd;

    logic [SQ_W-1:0]  sum_sq;
    logic [LEN_W-1:0] len;
    logic [QW-1:0]    quot_x, quot_y, quot_z;
    logic [TW-1:0]    term_mag [4];
    logic             term_neg [4];

    // Input unpacking
    assign pt_x        = s_axis_tdata[31:0];
    assign pt_y        = s_axis_tdata[63:32];
    assign pt_z        = s_axis_tdata[95:64];
    assign starts_path = s_axis_tuser[0];

    // Sequencer state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and unit controls
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sq_ctl        = '0;
        rt_ctl        = '0;
        dv_ctl        = '0;
        ml_ctl        = '0;
        rnd           = 1'b0;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && have_prev_reg && !starts_path)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                sq_ctl.load = 1'b1;
                cnt_next    = '0;
                state_next  = ST_SQ;
            end
            ST_SQ:
            begin
                sq_ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROOT_LD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT_LD:
            begin
                rt_ctl.load = 1'b1;
                state_next  = ST_ROOT;
            end
            ST_ROOT:
            begin
                rt_ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV_LD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV_LD:
            begin
                dv_ctl.load = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                dv_ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL_LD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL_LD:
            begin
                ml_ctl.load = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                ml_ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                rnd        = 1'b1;
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (cnt_reg == CNT_W'(3))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign seg_take = in_take && have_prev_reg && !starts_path;

    // Configuration registers; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_coef_reg <= '0;
            length_coef_reg <= '0;
            dir_x_coef_reg  <= '0;
            dir_y_coef_reg  <= '0;
            dir_z_coef_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OFFSET: offset_coef_reg <= cfg_data;
                REG_LENGTH: length_coef_reg <= cfg_data;
                REG_DIR_X:  dir_x_coef_reg  <= cfg_data;
                REG_DIR_Y:  dir_y_coef_reg  <= cfg_data;
                REG_DIR_Z:  dir_z_coef_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Previous waypoint flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (in_take)
        begin
            have_prev_reg <= 1'b1;
        end
    end

    // Previous waypoint and segment vector
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            prev_x_reg <= pt_x;
            prev_y_reg <= pt_y;
            prev_z_reg <= pt_z;
        end
        if (seg_take)
        begin
            dx_reg <= {pt_x[COORD_W-1], pt_x} - {prev_x_reg[COORD_W-1], prev_x_reg};
            dy_reg <= {pt_y[COORD_W-1], pt_y} - {prev_y_reg[COORD_W-1], prev_y_reg};
            dz_reg <= {pt_z[COORD_W-1], pt_z} - {prev_z_reg[COORD_W-1], prev_z_reg};
        end
    end

    // Component magnitudes; the segment vector holds still until the next item
    always_comb
    begin
        mag_x = dx_reg[DIFF_W-1] ? (~dx_reg + 1'b1) : dx_reg;
        mag_y = dy_reg[DIFF_W-1] ? (~dy_reg + 1'b1) : dy_reg;
        mag_z = dz_reg[DIFF_W-1] ? (~dz_reg + 1'b1) : dz_reg;
    end

    // Serial arithmetic units
    segtol_sqacc u_sqacc (
        .clk    (clk),
        .ctl    (sq_ctl),
        .mag_x  (mag_x),
        .mag_y  (mag_y),
        .mag_z  (mag_z),
        .sum_sq (sum_sq)
    );

    segtol_isqrt u_isqrt (
        .clk      (clk),
        .ctl      (rt_ctl),
        .radicand (sum_sq),
        .root     (len)
    );

    segtol_div #(.QW(QW)) u_div_x (
        .clk (clk), .ctl (dv_ctl), .mag (mag_x), .len (len), .quot (quot_x)
    );

    segtol_div #(.QW(QW)) u_div_y (
        .clk (clk), .ctl (dv_ctl), .mag (mag_y), .len (len), .quot (quot_y)
    );

    segtol_div #(.QW(QW)) u_div_z (
        .clk (clk), .ctl (dv_ctl), .mag (mag_z), .len (len), .quot (quot_z)
    );

    segtol_mul #(.FRAC(FRAC_BITS), .MW(MUL_STEPS)) u_mul_len (
        .clk    (clk),
        .ctl    (ml_ctl),
        .rnd    (rnd),
        .coef   (length_coef_reg),
        .mplier (len),
        .neg_in (1'b0),
        .term   (term_mag[0]),
        .neg    (term_neg[0])
    );

    segtol_mul #(.FRAC(FRAC_BITS), .MW(MUL_STEPS)) u_mul_x (
        .clk    (clk),
        .ctl    (ml_ctl),
        .rnd    (rnd),
        .coef   (dir_x_coef_reg),
        .mplier (LEN_W'(quot_x)),
        .neg_in (dx_reg[DIFF_W-1]),
        .term   (term_mag[1]),
        .neg    (term_neg[1])
    );

    segtol_mul #(.FRAC(FRAC_BITS), .MW(MUL_STEPS)) u_mul_y (
        .clk    (clk),
        .ctl    (ml_ctl),
        .rnd    (rnd),
        .coef   (dir_y_coef_reg),
        .mplier (LEN_W'(quot_y)),
        .neg_in (dy_reg[DIFF_W-1]),
        .term   (term_mag[2]),
        .neg    (term_neg[2])
    );

    segtol_mul #(.FRAC(FRAC_BITS), .MW(MUL_STEPS)) u_mul_z (
        .clk    (clk),
        .ctl    (ml_ctl),
        .rnd    (rnd),
        .coef   (dir_z_coef_reg),
        .mplier (LEN_W'(quot_z)),
        .neg_in (dz_reg[DIFF_W-1]),
        .term   (term_mag[3]),
        .neg    (term_neg[3])
    );

    // One term per cycle; direction terms drop out for a zero-length segment
    always_comb
    begin
        if (cnt_reg[1:0] != 2'd0 && zero_reg)
        begin
            addend = '0;
        end
        else
        begin
            addend = SUM_W'(term_mag[cnt_reg[1:0]]);
        end
    end

    // Zero-length flag and running sum
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV_LD)
        begin
            zero_reg <= (len == '0);
        end
        if (state_reg == ST_ROUND)
        begin
            sum_reg <= SUM_W'(offset_coef_reg);
        end
        else if (state_reg == ST_SUM)
        begin
            sum_reg <= term_neg[cnt_reg[1:0]] ? sum_reg - addend : sum_reg + addend;
        end
    end

    // Saturation to the signed 32-bit range
    always_comb
    begin
        clip_now = 1'b0;
        tol_sat  = sum_reg[31:0];
        if (sum_reg > SUM_MAX)
        begin
            clip_now = 1'b1;
            tol_sat  = TOL_MAX;
        end
        else if (sum_reg < SUM_MIN)
        begin
            clip_now = 1'b1;
            tol_sat  = TOL_MIN;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            tol_reg      <= tol_sat;
            out_zero_reg <= zero_reg;
            out_clip_reg <= clip_now;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tol_reg;
    assign m_axis_tuser  = {out_clip_reg, out_zero_reg};

    // A new result appears only from the final sequencer step
    a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result valid rose outside the final step");

    // The dividers start only after a complete square root
    a_root_complete : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_LD |->
            $past(state_reg) == ST_ROOT && $past(cnt_reg) == CNT_W'(ROOT_STEPS - 1))
        else $error("dividers loaded before the root was complete");

    // A finished result is held back while the output register is occupied
    a_fin_holds : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && m_axis_tvalid && !m_axis_tready |=> state_reg == ST_FIN)
        else $error("result overwritten while the previous one was stalled");

endmodule
